// ===== rtl/generational_bump_allocator_macros.svh =====
`ifndef GENERATIONAL_BUMP_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_BUMP_ALLOCATOR_MACROS_SVH

// Checks a condition in the same cycle as its trigger.
`define GBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks a condition in the cycle after its trigger.
`define GBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gba_pkg.sv =====
package gba_pkg;

  localparam int PAGE_BYTES    = 4096;
  localparam int POOL_PAGES    = 1024;
  localparam int HEADER_BYTES  = 40;
  localparam int HDR_ROUNDED   = ((HEADER_BYTES + 7) / 8) * 8;
  localparam int MAX_OBJ_BYTES = PAGE_BYTES - HDR_ROUNDED;

  localparam int NUM_HEAPS = 5;
  localparam int HEAP_W    = 3;
  localparam int OFF_W     = 13;
  localparam int BLK_W     = 11;
  localparam int OBJ_W     = 20;
  localparam int PAGES_W   = 11;
  localparam int SIZE_W    = 13;
  localparam int SUM_W     = 15;
  localparam int SHIFT_W   = 3;
  localparam int LA_SH_W   = OBJ_W + 7;
  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = 2;
  localparam int CNT_W     = 3;
  localparam int BIDX_W    = 10;
  localparam int BOFF_W    = 12;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_ADDR_W = 2;

  localparam logic [OFF_W-1:0]   HDR_OFF   = OFF_W'(HDR_ROUNDED);
  localparam logic [SIZE_W-1:0]  MAX_OBJ   = SIZE_W'(MAX_OBJ_BYTES);
  localparam logic [SUM_W-1:0]   PAGE_LIM  = SUM_W'(PAGE_BYTES);
  localparam logic [PAGES_W-1:0] POOL_LIM  = PAGES_W'(POOL_PAGES);
  localparam logic [BLK_W:0]     POOL_LIM_W = (BLK_W + 1)'(POOL_PAGES);
  localparam logic [PAGES_W-1:0] PAGES_RESET = PAGES_W'(3);
  localparam logic [BLK_W-1:0]   BLK_MAX   = '1;
  localparam logic [OBJ_W-1:0]   OBJ_MAX   = '1;

  localparam logic [HEAP_W-1:0] ROLE_YOUNG_SPARE = 3'd1;
  localparam logic [HEAP_W-1:0] ROLE_OLD         = 3'd2;
  localparam logic [HEAP_W-1:0] ROLE_OLD_SPARE   = 3'd3;
  localparam logic [HEAP_W-1:0] ROLE_STATIC      = 3'd4;
  localparam logic [HEAP_W-1:0] HEAP_STATIC      = 3'd4;

  localparam logic [1:0] LVL_NONE  = 2'd0;
  localparam logic [1:0] LVL_YOUNG = 2'd1;
  localparam logic [1:0] LVL_OLD   = 2'd2;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_END   = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_BIG    = 2'd1,
    ST_POOL_EMPTY = 2'd2
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_MIN    = 2'd1,
    CFG_MAX    = 2'd2,
    CFG_SHIFT  = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LATCH,
    S_CALC,
    S_WRITE,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [OBJ_W-1:0] last_alive;
    logic [OBJ_W-1:0] objects;
    logic [BLK_W-1:0] blocks;
    logic [OFF_W-1:0] offset;
  } heap_ent_t;

  localparam heap_ent_t HEAP_INIT_ENT = '{
    last_alive: '0,
    objects:    '0,
    blocks:     BLK_W'(1),
    offset:     HDR_OFF
  };

  typedef struct packed {
    logic                  enable;
    logic [BLK_W-1:0]      min_blocks;
    logic [BLK_W-1:0]      max_blocks;
    logic [SHIFT_W-1:0]    shift;
  } cfg_t;

  typedef struct packed {
    action_e             action;
    logic [HEAP_W-1:0]   target_heap;
    logic [SIZE_W-1:0]   obj_bytes;
  } item_t;

  typedef struct packed {
    status_e             status;
    logic [BIDX_W-1:0]   block_index;
    logic [BOFF_W-1:0]   byte_offset;
    logic                new_block;
    logic                collect_request;
    logic [1:0]          pending_level;
  } result_t;

  typedef struct packed {
    logic              re;
    logic [HEAP_W-1:0] raddr;
    logic              we;
    logic [HEAP_W-1:0] waddr;
    heap_ent_t         wdata;
  } ram_req_t;

endpackage

// ===== rtl/gba_heap_ram.sv =====
module gba_heap_ram import gba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ram_req_t  req_i,
  output heap_ent_t rdata_o
);

  heap_ent_t                mem_q [NUM_HEAPS];
  logic [NUM_HEAPS-1:0]     valid_q;
  heap_ent_t                rdata_q;

  function automatic heap_ent_t reset_ent(logic [HEAP_W-1:0] addr);
    heap_ent_t e;
    e = '0;
    if (addr[0] == 1'b0) begin
      e = HEAP_INIT_ENT;
    end
    return e;
  endfunction

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // Entries never written since reset read back as their reset contents.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      if (valid_q[req_i.raddr]) begin
        rdata_q <= mem_q[req_i.raddr];
      end else begin
        rdata_q <= reset_ent(req_i.raddr);
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gba_ctrl.sv =====
module gba_ctrl import gba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  input  item_t     item_i,
  output ram_req_t  ram_req_o,
  input  heap_ent_t ram_rdata_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output result_t   res_o
);

  state_e               state_q, state_d;
  item_t                item_q;
  logic [HEAP_W-1:0]    addr_q [NUM_SLOTS];
  logic [HEAP_W-1:0]    addr_d [NUM_SLOTS];
  logic [CNT_W-1:0]     n_q, n_d;
  logic [SLOT_W-1:0]    cnt_q, cnt_d;
  heap_ent_t            ent_q [NUM_SLOTS];
  heap_ent_t            ent_c [NUM_SLOTS];
  result_t              res_q, res_c;
  logic                 wr_ok_c;
  logic                 ys_q, ys_c, os_q, os_c, coll_q, coll_c;
  logic [PAGES_W-1:0]   pages_q, pages_c;
  logic [1:0]           cl_q, cl_c;
  logic                 accept;
  logic                 last_slot;

  function automatic logic [HEAP_W-1:0] role_heap(logic [HEAP_W-1:0] role, logic ys,
                                                  logic os);
    logic [HEAP_W-1:0] h;
    case (role)
      ROLE_YOUNG_SPARE: h = {2'b00, ~ys};
      ROLE_OLD:         h = {2'b01, os};
      ROLE_OLD_SPARE:   h = {2'b01, ~os};
      ROLE_STATIC:      h = HEAP_STATIC;
      default:          h = {2'b00, ys};
    endcase
    return h;
  endfunction

  function automatic logic [PAGES_W-1:0] sat_sub(logic [PAGES_W-1:0] a,
                                                 logic [BLK_W-1:0] b);
    logic [PAGES_W-1:0] r;
    if (BLK_W'(a) < b) begin
      r = '0;
    end else begin
      r = a - PAGES_W'(b);
    end
    return r;
  endfunction

  assign accept    = (state_q == S_IDLE) && item_valid_i;
  assign last_slot = (CNT_W'(cnt_q) + CNT_W'(1)) >= n_q;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      addr_d[i] = addr_q[i];
    end
    n_d = n_q;
    if (accept) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        addr_d[i] = '0;
      end
      n_d = '0;
      case (item_i.action)
        ACT_ALLOC: begin
          addr_d[0] = role_heap(item_i.target_heap, ys_q, os_q);
          n_d       = CNT_W'(1);
        end
        ACT_BEGIN: begin
          if (!coll_q) begin
            addr_d[0] = {2'b00, ~ys_q};
            addr_d[1] = {2'b01, ~os_q};
            n_d       = (cl_q >= LVL_OLD) ? CNT_W'(2) : CNT_W'(1);
          end
        end
        ACT_END: begin
          if (coll_q) begin
            addr_d[0] = {2'b00, ys_q};
            addr_d[1] = {2'b00, ~ys_q};
            addr_d[2] = {2'b01, os_q};
            addr_d[3] = {2'b01, ~os_q};
            n_d       = (cl_q >= LVL_OLD) ? CNT_W'(4) : CNT_W'(2);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    heap_ent_t          e;
    logic [SUM_W-1:0]   rnd;
    logic [SUM_W-1:0]   sum;
    logic               fit;
    logic               opened;
    logic [BLK_W-1:0]   blk_new;
    logic [BLK_W-1:0]   bidx_full;
    logic [OFF_W-1:0]   ptr;
    logic [LA_SH_W-1:0] la_sh;
    logic               fires;
    logic               is_old;
    logic               lvl2;
    logic [1:0]         lvl;
    logic [BLK_W:0]     freed;
    logic [BLK_W:0]     base;
    logic [BLK_W:0]     need;
    logic [PAGES_W-1:0] p;

    for (int i = 0; i < NUM_SLOTS; i++) begin
      ent_c[i] = ent_q[i];
    end
    wr_ok_c = 1'b0;
    res_c   = '0;
    ys_c    = ys_q;
    os_c    = os_q;
    coll_c  = coll_q;
    pages_c = pages_q;
    cl_c    = cl_q;
    lvl2    = (cl_q >= LVL_OLD);

    e         = ent_q[0];
    rnd       = (SUM_W'(item_q.obj_bytes) + SUM_W'(7)) & ~SUM_W'(7);
    sum       = SUM_W'(e.offset) + rnd;
    fit       = (e.blocks != '0) && (sum <= PAGE_LIM);
    opened    = !fit;
    blk_new   = (opened && (e.blocks != BLK_MAX)) ? e.blocks + BLK_W'(1) : e.blocks;
    bidx_full = blk_new - BLK_W'(1);
    ptr       = opened ? HDR_OFF : e.offset;
    is_old    = addr_q[0][1];
    lvl       = is_old ? LVL_OLD : LVL_YOUNG;
    la_sh     = LA_SH_W'(e.last_alive) << cfg_i.shift;
    fires     = (blk_new >= cfg_i.min_blocks) &&
                ((is_old && (blk_new > cfg_i.max_blocks)) || (LA_SH_W'(e.objects) > la_sh));

    freed = {1'b0, ent_q[0].blocks} + (lvl2 ? {1'b0, ent_q[1].blocks} : '0);
    base  = (freed > {1'b0, pages_q}) ? '0 : {1'b0, pages_q} - freed;
    need  = base + (lvl2 ? (BLK_W + 1)'(2) : (BLK_W + 1)'(1));
    p     = pages_q;

    case (item_q.action)
      ACT_ALLOC: begin
        if (item_q.obj_bytes > MAX_OBJ) begin
          res_c.status = ST_TOO_BIG;
        end else if (opened && (pages_q >= POOL_LIM)) begin
          res_c.status = ST_POOL_EMPTY;
        end else begin
          wr_ok_c = 1'b1;
          if (opened) begin
            pages_c = pages_q + PAGES_W'(1);
            if (!addr_q[0][2] && !coll_q && cfg_i.enable && fires && (lvl > cl_q)) begin
              cl_c = lvl;
            end
          end
          ent_c[0].offset  = ptr + rnd[OFF_W-1:0];
          ent_c[0].blocks  = blk_new;
          ent_c[0].objects = (e.objects != OBJ_MAX) ? e.objects + OBJ_W'(1) : e.objects;
          res_c.block_index = bidx_full[BIDX_W-1:0];
          res_c.byte_offset = ptr[BOFF_W-1:0];
          res_c.new_block   = opened;
        end
      end
      ACT_BEGIN: begin
        if (!coll_q) begin
          if (need > POOL_LIM_W) begin
            res_c.status = ST_POOL_EMPTY;
          end else begin
            wr_ok_c  = 1'b1;
            ent_c[0] = HEAP_INIT_ENT;
            p = sat_sub(pages_q, ent_q[0].blocks) + PAGES_W'(1);
            if (lvl2) begin
              ent_c[1] = HEAP_INIT_ENT;
              p = sat_sub(p, ent_q[1].blocks) + PAGES_W'(1);
            end
            pages_c = p;
            coll_c  = 1'b1;
            cl_c    = lvl2 ? LVL_OLD : LVL_YOUNG;
          end
        end
      end
      ACT_END: begin
        if (coll_q) begin
          wr_ok_c             = 1'b1;
          ys_c                = ~ys_q;
          p                   = sat_sub(pages_q, ent_q[0].blocks);
          ent_c[0]            = '0;
          ent_c[1].last_alive = ent_q[1].objects;
          if (lvl2) begin
            os_c                = ~os_q;
            p                   = sat_sub(p, ent_q[2].blocks);
            ent_c[2]            = '0;
            ent_c[3].last_alive = ent_q[3].objects;
          end
          pages_c = p;
          coll_c  = 1'b0;
          cl_c    = LVL_NONE;
        end
      end
      default: begin
      end
    endcase

    res_c.collect_request = (cl_c != LVL_NONE);
    res_c.pending_level   = cl_c;
  end

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    item_ready_o    = 1'b0;
    res_valid_o     = 1'b0;
    ram_req_o.re    = 1'b0;
    ram_req_o.we    = 1'b0;
    ram_req_o.raddr = addr_q[cnt_q];
    ram_req_o.waddr = addr_q[cnt_q];
    ram_req_o.wdata = ent_q[cnt_q];
    case (state_q)
      S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cnt_d   = '0;
          state_d = (n_d == '0) ? S_CALC : S_READ;
        end
      end
      S_READ: begin
        ram_req_o.re = 1'b1;
        state_d      = S_LATCH;
      end
      S_LATCH: begin
        if (last_slot) begin
          state_d = S_CALC;
        end else begin
          cnt_d   = cnt_q + SLOT_W'(1);
          state_d = S_READ;
        end
      end
      S_CALC: begin
        cnt_d   = '0;
        state_d = (wr_ok_c && (n_q != '0)) ? S_WRITE : S_OUT;
      end
      S_WRITE: begin
        ram_req_o.we = 1'b1;
        if (last_slot) begin
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q + SLOT_W'(1);
        end
      end
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      ys_q    <= 1'b0;
      os_q    <= 1'b0;
      coll_q  <= 1'b0;
      pages_q <= PAGES_RESET;
      cl_q    <= LVL_NONE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      if (state_q == S_CALC) begin
        ys_q    <= ys_c;
        os_q    <= os_c;
        coll_q  <= coll_c;
        pages_q <= pages_c;
        cl_q    <= cl_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      addr_q[i] <= addr_d[i];
    end
    if (state_q == S_LATCH) begin
      ent_q[cnt_q] <= ram_rdata_i;
    end
    if (state_q == S_CALC) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        ent_q[i] <= ent_c[i];
      end
      res_q <= res_c;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/generational_bump_allocator.sv =====
// Channel   Direction  Beat contents
// s_axis    in         tdata: obj_bytes; tuser: action, target_heap
// m_axis    out        tdata: block_index .. pending_level; tuser: status
// cfg       in         one register write per cycle with cfg_we_i high
//
// Before the next item is taken, each heap entry an item touches is read and
// captured, the update is computed, each entry is written back and the result
// is offered: one entry for an allocation, none for an ignored action, one or
// two for a begin, two or four for an end. A refused item skips the writes.
// Reset clears the roles and collection state and sets the page count to three.
// A stalled result port holds the beat in its register and the sequencer waits.
module generational_bump_allocator import gba_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [12:0] obj_bytes
  input  logic [4:0]            s_axis_tuser,   // [1:0] action, [4:2] target_heap
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [9:0] block_index, [21:10] byte_offset, [22] new_block,
  // [23] collect_request, [25:24] pending_level
  output logic [31:0]           m_axis_tdata,
  output logic [1:0]            m_axis_tuser,   // [1:0] status
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  `include "generational_bump_allocator_macros.svh"

  cfg_t      cfg_q;
  item_t     item;
  ram_req_t  ram_req;
  heap_ent_t ram_rdata;
  logic      res_valid;
  logic      res_ready;
  result_t   res;
  logic      out_valid_q;
  result_t   out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable     <= 1'b1;
      cfg_q.min_blocks <= BLK_W'(100);
      cfg_q.max_blocks <= BLK_W'(1000);
      cfg_q.shift      <= SHIFT_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_ENABLE: cfg_q.enable     <= cfg_wdata_i[0];
        CFG_MIN:    cfg_q.min_blocks <= cfg_wdata_i[BLK_W-1:0];
        CFG_MAX:    cfg_q.max_blocks <= cfg_wdata_i[BLK_W-1:0];
        CFG_SHIFT:  cfg_q.shift      <= cfg_wdata_i[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item.action      = action_e'(s_axis_tuser[1:0]);
  assign item.target_heap = s_axis_tuser[4:2];
  assign item.obj_bytes   = s_axis_tdata[SIZE_W-1:0];

  gba_heap_ram u_heap_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  gba_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (item),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {6'd0, out_q.pending_level, out_q.collect_request,
                          out_q.new_block, out_q.byte_offset, out_q.block_index};

  `GBA_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item accepted while busy")
  `GBA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result dropped while stalled")
  `GBA_ASSERT_NOW(a_fail_zero, out_valid_q && (out_q.status != ST_OK), (out_q.block_index == '0) && (out_q.byte_offset == '0) && !out_q.new_block, "failed item carries placement")
  `GBA_ASSERT_NOW(a_fresh_page, out_valid_q && out_q.new_block, (out_q.status == ST_OK) && (out_q.byte_offset == HDR_OFF[BOFF_W-1:0]), "new page not at header end")

endmodule

// ===== verif/bump_alloc_checker.sv =====
module bump_alloc_checker import gba_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,
  input  logic [4:0]            s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [31:0]           m_axis_tdata,
  input  logic [1:0]            m_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    outstanding_o,
  output int                    beats_in_o,
  output int                    beats_out_o,
  output int                    too_big_o,
  output int                    pool_empty_o,
  output int                    pages_opened_o,
  output int                    deep_collections_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LVL_NEVER  = 3;
  localparam int MAX_PRINTS = 50;

  logic [OFF_W-1:0]   page_off   [NUM_HEAPS];
  logic [BLK_W-1:0]   page_cnt   [NUM_HEAPS];
  logic [OBJ_W-1:0]   obj_cnt    [NUM_HEAPS];
  logic [OBJ_W-1:0]   survivors  [NUM_HEAPS];
  logic               young_slot;
  logic               old_slot;
  logic [PAGES_W-1:0] pool_used;
  logic [1:0]         gc_level;
  logic               gc_active;
  cfg_t               knobs;

  result_t outcome_q[$];
  item_t   taken_item;
  result_t seen_beat;
  result_t due_beat;

  task automatic flag(string msg);
    if (fail_count_o < MAX_PRINTS) begin
      $display("%0t ns: result beat %0d: %s", $realtime, beats_out_o, msg);
    end
    fail_count_o++;
  endtask

  function automatic void reset_model();
    for (int h = 0; h < NUM_HEAPS; h++) begin
      page_off[h]  = (h % 2 == 0) ? HDR_OFF : '0;
      page_cnt[h]  = (h % 2 == 0) ? BLK_W'(1) : '0;
      obj_cnt[h]   = '0;
      survivors[h] = '0;
    end
    young_slot        = 1'b0;
    old_slot          = 1'b0;
    pool_used         = PAGES_RESET;
    gc_level          = LVL_NONE;
    gc_active         = 1'b0;
    knobs.enable      = 1'b1;
    knobs.min_blocks  = BLK_W'(100);
    knobs.max_blocks  = BLK_W'(1000);
    knobs.shift       = SHIFT_W'(2);
    outcome_q.delete();
  endfunction

  function automatic int heap_for_role(logic [HEAP_W-1:0] role);
    case (role)
      ROLE_YOUNG_SPARE: return 1 - young_slot;
      ROLE_OLD:         return 2 + old_slot;
      ROLE_OLD_SPARE:   return 3 - old_slot;
      ROLE_STATIC:      return HEAP_STATIC;
      default:          return young_slot;
    endcase
  endfunction

  function automatic void check_trigger(int h);
    int                 lvl;
    logic [LA_SH_W-1:0] bar;
    logic [LA_SH_W-1:0] live;
    lvl = (h < 2) ? LVL_YOUNG : (h < 4) ? LVL_OLD : LVL_NEVER;
    if (lvl == LVL_NEVER || gc_active || !knobs.enable) return;
    if (page_cnt[h] < knobs.min_blocks) return;
    bar  = survivors[h];
    bar  = bar << knobs.shift;
    live = obj_cnt[h];
    if ((lvl == LVL_OLD && page_cnt[h] > knobs.max_blocks) || live > bar) begin
      if (lvl > gc_level) gc_level = 2'(lvl);
    end
  endfunction

  function automatic bit grab_page(int h);
    if (pool_used >= POOL_LIM) return 1'b0;
    pool_used++;
    if (page_cnt[h] != BLK_MAX) page_cnt[h]++;
    page_off[h] = HDR_OFF;
    pages_opened_o++;
    check_trigger(h);
    return 1'b1;
  endfunction

  function automatic void release_heap(int h);
    pool_used    = (page_cnt[h] > pool_used) ? '0 : pool_used - page_cnt[h];
    page_cnt[h]  = '0;
    page_off[h]  = '0;
    obj_cnt[h]   = '0;
    survivors[h] = '0;
  endfunction

  function automatic void prepare_spare(int h);
    release_heap(h);
    page_cnt[h] = BLK_W'(1);
    page_off[h] = HDR_OFF;
    pool_used++;
  endfunction

  function automatic result_t predict_outcome(item_t it);
    result_t res;
    int      h;
    int      rounded;
    int      at;
    int      lvl;
    int      freed;
    int      base;
    bit      placed;
    res        = '0;
    res.status = ST_OK;
    case (it.action)
      ACT_ALLOC: begin
        h = heap_for_role(it.target_heap);
        if (it.obj_bytes > MAX_OBJ) begin
          res.status = ST_TOO_BIG;
          too_big_o++;
        end else begin
          rounded = (int'(it.obj_bytes) + 7) & ~7;
          placed  = 1'b1;
          at      = 0;
          if (page_cnt[h] != '0 && int'(page_off[h]) + rounded <= PAGE_BYTES) begin
            at = page_off[h];
          end else if (grab_page(h)) begin
            at            = HDR_ROUNDED;
            res.new_block = 1'b1;
          end else begin
            placed     = 1'b0;
            res.status = ST_POOL_EMPTY;
            pool_empty_o++;
          end
          if (placed) begin
            page_off[h] = OFF_W'(at + rounded);
            if (obj_cnt[h] != OBJ_MAX) obj_cnt[h]++;
            res.block_index = BIDX_W'(page_cnt[h] - 1);
            res.byte_offset = BOFF_W'(at);
          end
        end
      end
      ACT_BEGIN: begin
        if (!gc_active) begin
          lvl   = (gc_level >= LVL_OLD) ? LVL_OLD : LVL_YOUNG;
          freed = page_cnt[1 - young_slot];
          if (lvl == LVL_OLD) freed += page_cnt[3 - old_slot];
          base = (freed > pool_used) ? 0 : pool_used - freed;
          if (base + lvl > POOL_PAGES) begin
            res.status = ST_POOL_EMPTY;
            pool_empty_o++;
          end else begin
            prepare_spare(1 - young_slot);
            if (lvl == LVL_OLD) begin
              prepare_spare(3 - old_slot);
              deep_collections_o++;
            end
            gc_active = 1'b1;
            gc_level  = 2'(lvl);
          end
        end
      end
      ACT_END: begin
        if (gc_active) begin
          lvl        = (gc_level >= LVL_OLD) ? LVL_OLD : LVL_YOUNG;
          young_slot = ~young_slot;
          release_heap(1 - young_slot);
          survivors[young_slot] = obj_cnt[young_slot];
          if (lvl == LVL_OLD) begin
            old_slot = ~old_slot;
            release_heap(3 - old_slot);
            survivors[2 + old_slot] = obj_cnt[2 + old_slot];
          end
          gc_level  = LVL_NONE;
          gc_active = 1'b0;
        end
      end
      default: ;
    endcase
    res.collect_request = (gc_level != LVL_NONE);
    res.pending_level   = gc_level;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      fail_count_o       = 0;
      beats_in_o         = 0;
      beats_out_o        = 0;
      too_big_o          = 0;
      pool_empty_o       = 0;
      pages_opened_o     = 0;
      deep_collections_o = 0;
      outstanding_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          CFG_ENABLE: knobs.enable     = cfg_wdata_i[0];
          CFG_MIN:    knobs.min_blocks = cfg_wdata_i;
          CFG_MAX:    knobs.max_blocks = cfg_wdata_i;
          CFG_SHIFT:  knobs.shift      = cfg_wdata_i[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen_beat.status          = status_e'(m_axis_tuser);
        seen_beat.block_index     = m_axis_tdata[9:0];
        seen_beat.byte_offset     = m_axis_tdata[21:10];
        seen_beat.new_block       = m_axis_tdata[22];
        seen_beat.collect_request = m_axis_tdata[23];
        seen_beat.pending_level   = m_axis_tdata[25:24];
        if (outcome_q.size() == 0) begin
          flag("result with no request outstanding");
        end else begin
          due_beat = outcome_q.pop_front();
          if (seen_beat.status !== due_beat.status)
            flag($sformatf("status %0d, expected %0d", seen_beat.status, due_beat.status));
          if (seen_beat.block_index !== due_beat.block_index)
            flag($sformatf("block_index %0d, expected %0d",
                           seen_beat.block_index, due_beat.block_index));
          if (seen_beat.byte_offset !== due_beat.byte_offset)
            flag($sformatf("byte_offset %0d, expected %0d",
                           seen_beat.byte_offset, due_beat.byte_offset));
          if (seen_beat.new_block !== due_beat.new_block)
            flag($sformatf("new_block %0b, expected %0b",
                           seen_beat.new_block, due_beat.new_block));
          if (seen_beat.collect_request !== due_beat.collect_request)
            flag($sformatf("collect_request %0b, expected %0b",
                           seen_beat.collect_request, due_beat.collect_request));
          if (seen_beat.pending_level !== due_beat.pending_level)
            flag($sformatf("pending_level %0d, expected %0d",
                           seen_beat.pending_level, due_beat.pending_level));
        end
        beats_out_o++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        taken_item.action      = action_e'(s_axis_tuser[1:0]);
        taken_item.target_heap = s_axis_tuser[4:2];
        taken_item.obj_bytes   = s_axis_tdata[SIZE_W-1:0];
        outcome_q.push_back(predict_outcome(taken_item));
        beats_in_o++;
      end
      outstanding_o <= outcome_q.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gba_pkg::*;

  localparam logic [HEAP_W-1:0] ROLE_YOUNG     = 3'd0;
  localparam logic [HEAP_W-1:0] ROLE_BAD_FIRST = 3'd5;
  localparam logic [HEAP_W-1:0] ROLE_BAD_LAST  = 3'd7;
  localparam int                TAIL_CYCLES    = 64;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;
  logic [4:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  int fails;
  int outstanding;
  int beats_in;
  int beats_out;
  int too_big;
  int pool_empty;
  int pages_opened;
  int deep_collections;

  int burst_left = 0;
  int rx_left    = 0;
  int rx_mode    = 0;
  logic [15:0] rx_mask = '0;

  generational_bump_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  bump_alloc_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tuser       (s_axis_tuser),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .m_axis_tuser       (m_axis_tuser),
    .cfg_we_i           (cfg_we_i),
    .cfg_addr_i         (cfg_addr_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .fail_count_o       (fails),
    .outstanding_o      (outstanding),
    .beats_in_o         (beats_in),
    .beats_out_o        (beats_out),
    .too_big_o          (too_big),
    .pool_empty_o       (pool_empty),
    .pages_opened_o     (pages_opened),
    .deep_collections_o (deep_collections)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
      rx_mask = 16'($urandom);
    end
    rx_left--;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= rx_mask[rx_left % 16];
    endcase
  end

  task automatic send_item(action_e act, logic [HEAP_W-1:0] role,
                           logic [SIZE_W-1:0] nbytes);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, nbytes};
    s_axis_tuser  <= {role, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
  endtask

  task automatic apply_settings(int en, int lo, int hi, int sh);
    wait_drained();
    write_reg(CFG_ENABLE, en);
    write_reg(CFG_MIN, lo);
    write_reg(CFG_MAX, hi);
    write_reg(CFG_SHIFT, sh);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [HEAP_W-1:0] pick_role();
    if ($urandom_range(0, 99) < 60) return ROLE_YOUNG;
    return HEAP_W'($urandom_range(0, 7));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(int big_pct);
    if ($urandom_range(0, 99) < big_pct)
      return SIZE_W'($urandom_range(3000, MAX_OBJ_BYTES));
    case ($urandom_range(0, 7))
      0, 1, 2: return SIZE_W'($urandom_range(0, 64));
      3:       return SIZE_W'($urandom_range(65, 1023));
      4, 5:    return SIZE_W'($urandom_range(1024, MAX_OBJ_BYTES));
      6:       return SIZE_W'($urandom_range(MAX_OBJ_BYTES - 8, MAX_OBJ_BYTES + 8));
      default: return SIZE_W'($urandom_range(MAX_OBJ_BYTES + 1, 8191));
    endcase
  endfunction

  task automatic run_traffic(int n, int big_pct);
    int sent;
    int mutators;
    int copies;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 85) begin
        mutators = $urandom_range(1, 12);
        copies   = $urandom_range(0, 6);
        repeat (mutators) send_item(ACT_ALLOC, pick_role(), pick_size(big_pct));
        send_item(ACT_BEGIN, HEAP_W'($urandom_range(0, 7)), SIZE_W'($urandom));
        repeat (copies) begin
          send_item(ACT_ALLOC, $urandom_range(0, 1) ? ROLE_YOUNG_SPARE : ROLE_OLD_SPARE,
                    pick_size(big_pct));
        end
        send_item(ACT_END, HEAP_W'($urandom_range(0, 7)), SIZE_W'($urandom));
        sent += mutators + copies + 2;
      end else begin
        send_item(action_e'($urandom_range(0, 3)), HEAP_W'($urandom_range(0, 7)),
                  SIZE_W'($urandom_range(0, 8191)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ACT_NOP, ROLE_BAD_LAST, 13'h1FFF);
    send_item(ACT_END, ROLE_YOUNG, 0);
    send_item(ACT_ALLOC, ROLE_YOUNG, 0);
    send_item(ACT_ALLOC, ROLE_YOUNG, 1);
    send_item(ACT_ALLOC, ROLE_YOUNG_SPARE, 8);
    send_item(ACT_ALLOC, ROLE_OLD, MAX_OBJ);
    send_item(ACT_ALLOC, ROLE_OLD, 9);
    send_item(ACT_ALLOC, ROLE_OLD_SPARE, 100);
    send_item(ACT_ALLOC, ROLE_STATIC, MAX_OBJ);
    send_item(ACT_ALLOC, ROLE_STATIC, MAX_OBJ + SIZE_W'(1));
    send_item(ACT_ALLOC, ROLE_BAD_FIRST, 17);
    send_item(ACT_ALLOC, ROLE_BAD_FIRST + HEAP_W'(1), 4095);
    send_item(ACT_ALLOC, ROLE_BAD_LAST, 13'h1FFF);
    send_item(ACT_ALLOC, ROLE_YOUNG, SIZE_W'(PAGE_BYTES));
    send_item(ACT_BEGIN, ROLE_YOUNG, 0);
    send_item(ACT_BEGIN, ROLE_OLD, 0);
    send_item(ACT_ALLOC, ROLE_YOUNG_SPARE, 64);
    send_item(ACT_ALLOC, ROLE_OLD_SPARE, 64);
    send_item(ACT_END, ROLE_YOUNG, 0);
    send_item(ACT_END, ROLE_YOUNG, 0);
    send_item(ACT_ALLOC, ROLE_YOUNG, MAX_OBJ - SIZE_W'(1));
    send_item(ACT_ALLOC, ROLE_YOUNG, MAX_OBJ);
    send_item(ACT_NOP, ROLE_YOUNG, 0);

    apply_settings(1, 0, 0, 0);
    run_traffic(230, 10);
    apply_settings(1, 1024, 1024, 7);
    run_traffic(190, 40);
    apply_settings(0, 0, 0, 0);
    run_traffic(150, 20);
    apply_settings(1, 2, 5, 1);
    run_traffic(190, 25);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests and %0d checked responses over five settings.",
             beats_in, beats_out);
    $display("Seen: %0d oversize, %0d pool refusals, %0d pages opened, %0d two-level begins.",
             too_big, pool_empty, pages_opened, deep_collections);
    if (fails == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Timed out with %0d responses outstanding.", outstanding);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gba_pkg.sv
rtl/gba_heap_ram.sv
rtl/gba_ctrl.sv
rtl/generational_bump_allocator.sv
verif/bump_alloc_checker.sv
verif/tb.sv
